// File: rtl/core/bdq_pkg.sv
package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int POS_W = 5;
	localparam int STAT_W = 3;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK = 3'd1,
		MODE_POP_FRONT = 3'd2,
		MODE_POP_BACK = 3'd3,
		MODE_REMOVE_AT = 3'd4,
		MODE_REMOVE_VAL = 3'd5,
		MODE_READ_AT = 3'd6,
		MODE_CLEAR = 3'd7
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_HOLD,
		K_PUSH_FRONT,
		K_PUSH_BACK,
		K_SHIFT,
		K_MATCH
	} kind_t;

	// broadcast to every cell for the request being accepted
	typedef struct packed {
		kind_t kind;
		logic signed [DATA_W-1:0] value;
		logic [CW-1:0] pos;
		logic [CW-1:0] count;
	} cmd_t;

	// selects for the read-back chain
	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic bk_en;
		logic [IDX_W-1:0] bk_idx;
	} view_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rd;
		logic signed [DATA_W-1:0] bk;
	} bus_t;

endpackage

// File: rtl/core/bdq_cell.sv
module bdq_cell
	import bdq_pkg::*;
(
	input logic clk,
	input logic [IDX_W-1:0] idx,
	input cmd_t cmd,
	input logic signed [DATA_W-1:0] left_value,
	input logic signed [DATA_W-1:0] right_value,
	output logic signed [DATA_W-1:0] value,
	input logic hit_in,
	output logic hit_out,
	input view_t view,
	input bus_t bus_in,
	output bus_t bus_out
);

	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] value_d;
	logic [CW-1:0] idx_ext;
	logic match;

	assign idx_ext = CW'(idx);
	assign match = (value_q == cmd.value) && (idx_ext < cmd.count);
	assign hit_out = hit_in | match;
	assign value = value_q;

	always_comb begin
		value_d = value_q;
		case (cmd.kind)
			K_PUSH_FRONT: begin
				value_d = (idx_ext == '0) ? cmd.value : left_value;
			end
			K_PUSH_BACK: begin
				if (idx_ext == cmd.count) value_d = cmd.value;
			end
			K_SHIFT: begin
				if (idx_ext >= cmd.pos) value_d = right_value;
			end
			K_MATCH: begin
				if (hit_out) value_d = right_value;
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	always_comb begin
		bus_out = bus_in;
		if (view.rd_en && view.rd_idx == idx) bus_out.rd = bus_in.rd | value_q;
		if (view.bk_en && view.bk_idx == idx) bus_out.bk = bus_in.bk | value_q;
	end

endmodule

// File: rtl/core/bounded_deque_with_delete.sv
// Bounded deque with indexed removal, up to DEPTH signed 32-bit words.
// Request channel: req_valid/req_stall with mode, item_value, position.
// Response channel: rsp_valid/rsp_stall with status, read_value, front_value,
// back_value, length, is_empty; exactly one response per request, in order.
// Storage is a row of identical cells; every request shifts, loads or holds
// all cells at the edge where it is accepted, so a request can be taken every
// cycle while req_stall is low. An accepted request enters a middle stage;
// there front, back and read values are gathered over the cell chain, and
// they move into the output register when the response register can advance.
// A failed request (nonzero status) leaves the list unchanged.
// Reset empties the list and drops any response in flight; cell contents
// are not cleared, only the count.
// When rsp_stall is held the response stays registered, one more request
// may enter the middle stage, and then req_stall rises until the response
// is taken.
module bounded_deque_with_delete
	import bdq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [2:0] mode,
	input logic signed [DATA_W-1:0] item_value,
	input logic [POS_W-1:0] position,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [STAT_W-1:0] status,
	output logic signed [DATA_W-1:0] read_value,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic [POS_W-1:0] length,
	output logic is_empty
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic valid_s1;
	status_t status_s1;
	logic rd_en_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic signed [DATA_W-1:0] front_value_q;
	logic signed [DATA_W-1:0] back_value_q;
	logic [POS_W-1:0] length_q;
	logic is_empty_q;

	logic adv;
	logic req_accept;
	cmd_t cmd;
	status_t st_d;
	logic rd_en_d;
	logic [CW-1:0] count_ext;
	logic [CW-1:0] pos_ext;
	logic full;
	logic empty;
	view_t view;

	logic signed [DATA_W-1:0] vals [DEPTH];
	logic hit [DEPTH+1];
	bus_t bus [DEPTH+1];

	assign adv = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign req_accept = req_valid && !req_stall;

	assign count_ext = CW'(count_q);
	assign pos_ext = CW'(position);
	assign full = (count_ext == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.kind = K_HOLD;
		cmd.value = item_value;
		cmd.pos = pos_ext;
		cmd.count = count_ext;
		st_d = ST_OK;
		rd_en_d = 1'b0;
		count_d = count_q;
		case (mode_t'(mode))
			MODE_PUSH_FRONT: begin
				if (full) st_d = ST_FULL;
				else begin
					cmd.kind = K_PUSH_FRONT;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_PUSH_BACK: begin
				if (full) st_d = ST_FULL;
				else begin
					cmd.kind = K_PUSH_BACK;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) st_d = ST_EMPTY;
				else begin
					cmd.kind = K_SHIFT;
					cmd.pos = '0;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_POP_BACK: begin
				if (empty) st_d = ST_EMPTY;
				else count_d = count_q - CNT_W'(1);
			end
			MODE_REMOVE_AT: begin
				if (empty) st_d = ST_EMPTY;
				else if (pos_ext >= count_ext) st_d = ST_RANGE;
				else begin
					cmd.kind = K_SHIFT;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_REMOVE_VAL: begin
				if (empty) st_d = ST_EMPTY;
				else if (!hit[DEPTH]) st_d = ST_NOTFOUND;
				else begin
					cmd.kind = K_MATCH;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_READ_AT: begin
				if (empty) st_d = ST_EMPTY;
				else if (pos_ext == '0 || pos_ext > count_ext) st_d = ST_RANGE;
				else rd_en_d = 1'b1;
			end
			MODE_CLEAR: begin
				if (empty) st_d = ST_EMPTY;
				else count_d = '0;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
		if (!req_accept) begin
			cmd.kind = K_HOLD;
		end
	end

	assign hit[0] = 1'b0;
	assign bus[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdq_cell u_cell (
			.clk(clk),
			.idx(IDX_W'(i)),
			.cmd(cmd),
			.left_value((i == 0) ? '0 : vals[(i == 0) ? 0 : i - 1]),
			.right_value((i == DEPTH - 1) ? '0 : vals[(i == DEPTH - 1) ? i : i + 1]),
			.value(vals[i]),
			.hit_in(hit[i]),
			.hit_out(hit[i+1]),
			.view(view),
			.bus_in(bus[i]),
			.bus_out(bus[i+1])
		);
	end

	always_comb begin
		view.rd_en = rd_en_s1;
		view.rd_idx = rd_idx_s1;
		view.bk_en = !empty;
		view.bk_idx = IDX_W'(count_q - CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				count_q <= count_d;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			status_s1 <= st_d;
			rd_en_s1 <= rd_en_d;
			rd_idx_s1 <= IDX_W'(pos_ext - CW'(1));
		end
		if (adv && valid_s1) begin
			status_q <= status_s1;
			read_value_q <= bus[DEPTH].rd;
			front_value_q <= empty ? '0 : vals[0];
			back_value_q <= bus[DEPTH].bk;
			length_q <= POS_W'(count_ext);
			is_empty_q <= empty;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign read_value = read_value_q;
	assign front_value = front_value_q;
	assign back_value = back_value_q;
	assign length = length_q;
	assign is_empty = is_empty_q;

endmodule
